// ===== hdl/ssse_pkg.sv =====
// Package for the segmented space symbol encoder.
// Holds shared constants, codes, types and small helpers; no dependencies.
package ssse_pkg;

  localparam int MAX_DIMS    = 3;
  localparam int MAX_CHUNKS  = 64;
  localparam int MAX_LEVELS  = 16;
  localparam int ADDR_W      = 12;
  localparam int OFS_W       = 6;   // entries per chunk is 64
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 48;

  localparam logic [1:0] KIND_LEVEL = 2'd0;
  localparam logic [1:0] KIND_RES   = 2'd1;
  localparam logic [1:0] KIND_OOS   = 2'd2;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_ENCODE = 1'b1;

  localparam logic [2:0] REG_DIMS    = 3'd0;
  localparam logic [2:0] REG_STEPS   = 3'd1;
  localparam logic [2:0] REG_OUTER   = 3'd2;
  localparam logic [2:0] REG_CX      = 3'd3;
  localparam logic [2:0] REG_CY      = 3'd4;
  localparam logic [2:0] REG_CZ      = 3'd5;
  localparam logic [2:0] REG_CHUNKS  = 3'd6;

  typedef logic signed [19:0] wide_t;

  typedef struct packed {
    logic [1:0]         dims;
    logic [2:0]         steps;
    logic [15:0]        outer;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic [6:0]         chunks;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic init;
    logic div;
    logic bin;
    logic emit_lvl;
    logic emit_res;
    logic emit_oos;
  } cmd_t;

  typedef struct packed {
    logic in_space;
    logic walk_more;
    logic next_walk;
    logic res_more;
    logic res_last;
    logic out_free;
  } sts_t;

  // steps clamped to 2..4
  function automatic logic [2:0] clamp_steps(input logic [2:0] s);
    logic [2:0] r;
    r = s;
    if (s < 3'd2) r = 3'd2;
    else if (s > 3'd4) r = 3'd4;
    return r;
  endfunction

  // steps^dims - 1, offset of a chunk's last entry
  function automatic logic [OFS_W-1:0] last_ofs(input logic [2:0] st, input logic [1:0] d);
    logic [6:0] p;
    p = 7'd1;
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (k < int'(d)) p = 7'(p * st);
    end
    return OFS_W'(p - 7'd1);
  endfunction

endpackage

// ===== hdl/ssse_cfg.sv =====
// Register file for the segmented space symbol encoder (APB-style port).
// Depends on ssse_pkg.
module ssse_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output ssse_pkg::cfg_t      cfg
);
  import ssse_pkg::*;

  cfg_t       cfg_r;
  logic       wr;
  logic [2:0] idx;

  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dims   <= 2'd3;
      cfg_r.steps  <= 3'd2;
      cfg_r.outer  <= 16'd256;
      cfg_r.cx     <= '0;
      cfg_r.cy     <= '0;
      cfg_r.cz     <= '0;
      cfg_r.chunks <= 7'd1;
    end else if (wr) begin
      unique case (idx)
        REG_DIMS:   cfg_r.dims   <= cfg_pwdata[1:0];
        REG_STEPS:  cfg_r.steps  <= cfg_pwdata[2:0];
        REG_OUTER:  cfg_r.outer  <= cfg_pwdata[15:0];
        REG_CX:     cfg_r.cx     <= cfg_pwdata[15:0];
        REG_CY:     cfg_r.cy     <= cfg_pwdata[15:0];
        REG_CZ:     cfg_r.cz     <= cfg_pwdata[15:0];
        REG_CHUNKS: cfg_r.chunks <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DIMS:   cfg_prdata = {30'd0, cfg_r.dims};
      REG_STEPS:  cfg_prdata = {29'd0, cfg_r.steps};
      REG_OUTER:  cfg_prdata = {16'd0, cfg_r.outer};
      REG_CX:     cfg_prdata = {16'd0, cfg_r.cx};
      REG_CY:     cfg_prdata = {16'd0, cfg_r.cy};
      REG_CZ:     cfg_prdata = {16'd0, cfg_r.cz};
      REG_CHUNKS: cfg_prdata = {25'd0, cfg_r.chunks};
      default:    cfg_prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/ssse_ctrl.sv =====
// Sequencer for the segmented space symbol encoder.
// Depends on ssse_pkg; drives the datapath by command struct.
module ssse_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tuser,
  output logic           in_tready,
  input  ssse_pkg::sts_t sts,
  output ssse_pkg::cmd_t cmd
);
  import ssse_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_BIN  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_RES  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_tuser == ACT_ENCODE) begin
            cmd.init  = 1'b1;
            state_nxt = S_CHK;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_CHK: begin
        if (!sts.in_space) begin
          if (sts.out_free) begin
            cmd.emit_oos = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.walk_more) begin
          state_nxt = S_DIV;
        end else if (sts.res_more) begin
          state_nxt = S_RES;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_BIN;
      end
      S_BIN: begin
        cmd.bin   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_lvl = 1'b1;
          if (sts.next_walk)     state_nxt = S_DIV;
          else if (sts.res_more) state_nxt = S_RES;
          else                   state_nxt = S_IDLE;
        end
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.emit_res = 1'b1;
          if (sts.res_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hdl/ssse_dp.sv =====
// Datapath for the segmented space symbol encoder: tables, cell walk, output register.
// Depends on ssse_pkg.
module ssse_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ssse_pkg::cfg_t                       cfg,
  input  ssse_pkg::cmd_t                       cmd,
  output ssse_pkg::sts_t                       sts,
  input  logic [ssse_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ssse_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [1:0]                           out_tuser,
  output logic                                 out_tlast
);
  import ssse_pkg::*;

  // tables
  logic [15:0] low_mem   [0:(1<<ADDR_W)-1];
  logic [15:0] count_mem [0:(1<<ADDR_W)-1];
  logic [6:0]  link_mem  [0:(1<<ADDR_W)-1];

  logic [ADDR_W-1:0] ld_idx;
  logic [15:0]       ld_cnt, ld_base, run_low_r;
  logic [6:0]        ld_link;

  // walk state
  wide_t       c_r   [MAX_DIMS];
  wide_t       ext_r [MAX_DIMS];
  wide_t       ext_n [MAX_DIMS];
  logic [1:0]  bin   [MAX_DIMS];
  logic [15:0] size_r;
  logic [6:0]  chunk_r;
  logic [4:0]  level_r;
  logic [1:0]  res_idx_r;
  logic [15:0] low_e_r, cnt_e_r, low_t_r, cnt_t_r;
  logic [6:0]  link_e_r;

  logic [2:0]        st;
  logic [6:0]        nchunks;
  logic [OFS_W-1:0]  ofs, ent_m1;
  logic [ADDR_W-1:0] addr_e, addr_t;
  logic [32:0]       prod3;
  logic [15:0]       size_div;
  wide_t             half, size_w, res_val, pt[MAX_DIMS];
  logic              found;
  logic              in_space_c;
  logic [15:0]       tot;

  logic              ov_r, last_r;
  logic [1:0]        kind_r;
  logic [15:0]       o_tot_r, o_low_r, o_cnt_r;

  assign st      = clamp_steps(cfg.steps);
  assign nchunks = (cfg.chunks > 7'(MAX_CHUNKS)) ? 7'(MAX_CHUNKS) : cfg.chunks;
  assign ent_m1  = last_ofs(st, cfg.dims);
  assign half    = wide_t'({4'd0, cfg.outer} >> 1);
  assign size_w  = wide_t'({4'd0, size_r});

  assign ld_idx  = in_tdata[11:0];
  assign ld_cnt  = in_tdata[27:12];
  assign ld_link = in_tdata[34:28];
  assign ld_base = (ld_idx[OFS_W-1:0] == '0) ? 16'd0 : run_low_r;

  assign pt[0] = wide_t'($signed(in_tdata[50:35])) - wide_t'(cfg.cx);
  assign pt[1] = wide_t'($signed(in_tdata[66:51])) - wide_t'(cfg.cy);
  assign pt[2] = wide_t'($signed(in_tdata[82:67])) - wide_t'(cfg.cz);

  // size / steps: shifts, or reciprocal multiply for three
  assign prod3 = 33'(size_r) * 33'd43691;
  always_comb begin
    unique case (st)
      3'd3:    size_div = prod3[32:17];
      3'd4:    size_div = size_r >> 2;
      default: size_div = size_r >> 1;
    endcase
  end

  // bin pick per dimension: first j with c < ext + size*(j+1)
  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      bin[i]   = 2'd0;
      ext_n[i] = ext_r[i];
      found    = 1'b0;
      if (i < int'(cfg.dims)) begin
        for (int j = 0; j < 4; j++) begin
          if (!found && j < int'(st) &&
              c_r[i] < ext_r[i] + size_w * wide_t'(j + 1)) begin
            bin[i]   = 2'(j);
            ext_n[i] = ext_r[i] + size_w * wide_t'(j);
            found    = 1'b1;
          end
        end
      end
    end
    ofs = OFS_W'(bin[0]) + OFS_W'(st) * OFS_W'(bin[1]) +
          OFS_W'(st) * OFS_W'(st) * OFS_W'(bin[2]);
  end

  assign addr_e = {chunk_r[5:0], ofs};
  assign addr_t = {chunk_r[5:0], ent_m1};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      low_mem[ld_idx]   <= ld_base;
      count_mem[ld_idx] <= ld_cnt;
      link_mem[ld_idx]  <= ld_link;
    end
    if (cmd.bin) begin
      low_e_r  <= low_mem[addr_e];
      cnt_e_r  <= count_mem[addr_e];
      link_e_r <= link_mem[addr_e];
      low_t_r  <= low_mem[addr_t];
      cnt_t_r  <= count_mem[addr_t];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) run_low_r <= 16'd0;
    else if (cmd.load) run_low_r <= ld_base + ld_cnt;
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        c_r[i]   <= pt[i];
        ext_r[i] <= -half;
      end
      size_r    <= cfg.outer;
      chunk_r   <= 7'd0;
      level_r   <= 5'd0;
      res_idx_r <= 2'd0;
    end
    if (cmd.div) size_r <= size_div;
    if (cmd.bin) begin
      for (int i = 0; i < MAX_DIMS; i++) ext_r[i] <= ext_n[i];
    end
    if (cmd.emit_lvl) begin
      chunk_r <= link_e_r;
      level_r <= level_r + 5'd1;
    end
    if (cmd.emit_res) res_idx_r <= res_idx_r + 2'd1;
  end

  always_comb begin
    in_space_c = 1'b1;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (i < int'(cfg.dims) && !(c_r[i] < half && c_r[i] > -half)) in_space_c = 1'b0;
    end
  end
  assign sts.in_space  = in_space_c;
  assign sts.walk_more = (chunk_r < nchunks) && (level_r < 5'(MAX_LEVELS));
  assign sts.next_walk = (link_e_r < nchunks) && (level_r < 5'(MAX_LEVELS - 1));
  assign sts.res_more  = (size_r > 16'd1) && (cfg.dims != 2'd0);
  assign sts.res_last  = (res_idx_r == cfg.dims - 2'd1);
  assign sts.out_free  = !ov_r || out_tready;

  always_comb begin
    unique case (res_idx_r)
      2'd1:    res_val = c_r[1] - ext_r[1];
      2'd2:    res_val = c_r[2] - ext_r[2];
      default: res_val = c_r[0] - ext_r[0];
    endcase
  end
  assign tot = low_t_r + cnt_t_r;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.emit_lvl || cmd.emit_res || cmd.emit_oos) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_oos) begin
      kind_r  <= KIND_OOS;
      o_tot_r <= 16'd0;
      o_low_r <= 16'd0;
      o_cnt_r <= 16'd0;
      last_r  <= 1'b1;
    end else if (cmd.emit_lvl) begin
      kind_r  <= KIND_LEVEL;
      o_tot_r <= tot;
      o_low_r <= low_e_r;
      o_cnt_r <= cnt_e_r;
      last_r  <= !sts.next_walk && !sts.res_more;
    end else if (cmd.emit_res) begin
      kind_r  <= KIND_RES;
      o_tot_r <= size_r;
      o_low_r <= res_val[15:0];
      o_cnt_r <= 16'd1;
      last_r  <= sts.res_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {o_cnt_r, o_low_r, o_tot_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

// ===== hdl/segmented_space_symbol_encoder.sv =====
// Top level of the segmented space symbol encoder.
// Depends on ssse_pkg, ssse_cfg, ssse_ctrl and ssse_dp.
//
// Usage:
//  - Configure through the cfg_ APB-style port while idle; pready is always high.
//  - Load the chunk tree with action=0 transfers on the in_ channel, in order
//    within each chunk; each load yields no result.
//  - An action=1 transfer encodes a point. Out-of-space points give one
//    result (kind 2). Otherwise one level result per tree level, then one
//    residual per dimension if the final cell is wider than one; tlast marks
//    the final result.
//  - Sequence: the point is checked, then each level passes through the divide
//    register, table read and output load states, then each residual is
//    emitted in turn. One encode at a time.
//  - The output register holds a result while out_tready is low; the walk
//    waits on it. The next item is taken once the last result is registered.
//  - Reset (rst_n low, synchronous) restores register defaults, empties the
//    output and clears the load running low; table contents are undefined
//    until loaded.
module segmented_space_symbol_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // entry_index[11:0], entry_count[27:12],
                                  // entry_link[34:28], coord_x[50:35],
                                  // coord_y[66:51], coord_z[82:67], zero pad
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // sym_total[15:0], sym_low[31:16], sym_count[47:32]
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,  // last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ssse_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // register file
  ssse_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  // sequencer: one encode at a time
  ssse_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tuser, .in_tready, .sts, .cmd
  );

  // tables, walk arithmetic and output register
  ssse_dp u_dp (
    .clk, .rst_n, .cfg, .cmd, .sts, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

endmodule

// ===== hdl/ssse_chk.sv =====
// Port-level checker for the segmented space symbol encoder, with bind.
// Depends on ssse_pkg.
module ssse_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import ssse_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_oos_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_OOS |-> out_tlast && out_tdata == 48'd0)
    else $error("out-of-space result malformed");

  a_res_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_RES |-> out_tdata[47:32] == 16'd1)
    else $error("residual count not one");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("unused kind code");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind segmented_space_symbol_encoder ssse_chk u_ssse_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
);
